// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by bitmap_run_allocator.
// Expects signals named clock and reset (synchronous, active high) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BRA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define BRA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) ante |=> cons) else $error(msg);

`endif

// ===== rtl/core/bra_pkg.sv =====
// Package for the bitmap run allocator: sizes, operation and status codes,
// and the byte step result passed between the scan unit and the top level.
package bra_pkg;

   localparam int MAP_BYTES = 512;
   localparam int ADDR_W    = $clog2(MAP_BYTES);
   localparam int BYTE_W    = 8;
   localparam int POS_W     = 3;
   localparam int IDX_W     = 12;
   localparam int LEN_W     = 13;
   localparam int BIU_W     = 10;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_TEST  = 2'd1,
      OP_SCAN  = 2'd2,
      OP_WRITE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_NO_RUN = 2'd1,
      STATUS_RANGE  = 2'd2,
      STATUS_RSVD   = 2'd3
   } status_type;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] next_count;
   } step_res_type;

endpackage

// ===== rtl/core/bra_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module bra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/bra_run_step.sv =====
// Free-run counter step over one bitmap byte: carries the run count through
// eight bits and reports the first bit where the run reaches the length. Uses bra_pkg.
module bra_run_step
   import bra_pkg::*;
(
   input  logic [BYTE_W-1:0] byte_data,
   input  logic [LEN_W-1:0]  carry_count,
   input  logic [LEN_W-1:0]  run_length,
   output step_res_type      res
);

   logic [LEN_W-1:0]  cnt [BYTE_W];
   logic [BYTE_W-1:0] match;

   always_comb begin
      for (int j = 0; j < BYTE_W; j++) begin
         cnt[j] = carry_count + LEN_W'(j + 1);
         for (int k = 0; k < BYTE_W; k++) begin
            if (k <= j && byte_data[k]) begin
               cnt[j] = LEN_W'(j - k);
            end
         end
         match[j] = (cnt[j] == run_length);
      end
   end

   always_comb begin
      res.found      = |match;
      res.pos        = '0;
      res.next_count = cnt[BYTE_W-1];
      for (int j = BYTE_W - 1; j >= 0; j--) begin
         if (match[j]) begin
            res.pos = POS_W'(j);
         end
      end
   end

endmodule

// ===== rtl/core/bitmap_run_allocator.sv =====
// Bitmap run allocator: occupancy bitmap in a byte RAM with clear, test, write
// and first-fit run scan. Uses bra_pkg, bra_ram, bra_run_step, assert_macros.svh.
//
// Usage:
//   req_* carries one operation word; rsp_* returns exactly one result word
//   for each. csr_* writes bytes_in_use (values above 512 act as 512) and
//   must only be written while no operation is in flight.
//   Steps from the accepting edge until rsp_tvalid rises, rsp_tready high:
//     test and write     : RAM read, then read or update
//     out of range       : straight to the result register
//     scan               : the byte RAM read port feeds one byte per cycle
//                          to the run counter, up to the bytes in use
//     clear              : all 512 RAM bytes zeroed, one byte per cycle
//   One operation is worked on at a time; req_tready is high only when the
//   sequencer is idle. The result sits in an output register, so the next
//   operation may be accepted while rsp_tvalid waits on rsp_tready; a second
//   result then holds in the sequencer until the register empties.
//   After reset a clearing pass zeroes the bitmap with req_tready
//   low; bytes_in_use resets to 512. csr_tready is always high.
`include "assert_macros.svh"

module bitmap_run_allocator
   import bra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // bit_index[11:0], bit_value[12], run_length[25:13]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // bit_state[0], run_start[12:1]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [15:0] csr_tdata    // bytes_in_use[9:0]
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CLEAR = 6'b000010,
      ST_TEST  = 6'b000100,
      ST_WRUPD = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic [BIU_W-1:0]   biu_ff, biu_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_state_ff, rsp_state_in;
   logic [IDX_W-1:0]   rsp_start_ff, rsp_start_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic               res_state_ff, res_state_in;
   logic [IDX_W-1:0]   res_start_ff, res_start_in;
   status_type         res_status_ff, res_status_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               val_ff, val_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [LEN_W-1:0]   run_cnt_ff, run_cnt_in;
   logic [BIU_W-1:0]   eval_ff, eval_in;
   logic [BIU_W-1:0]   next_addr_ff, next_addr_in;

   op_type             req_op;
   logic [IDX_W-1:0]   req_idx;
   logic               req_val;
   logic [LEN_W-1:0]   req_len;
   logic               req_fire;
   logic [BIU_W-1:0]   eff_bytes;
   logic [LEN_W-1:0]   total_bits;
   logic               idx_bad;
   logic               len_bad;

   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [BYTE_W-1:0]  ram_wdata;
   logic [ADDR_W-1:0]  ram_raddr;
   logic [BYTE_W-1:0]  ram_rdata;
   logic [BYTE_W-1:0]  bit_mask;

   step_res_type       step;
   logic [LEN_W-1:0]   scan_start;

   assign req_op     = op_type'(req_tuser);
   assign req_idx    = req_tdata[11:0];
   assign req_val    = req_tdata[12];
   assign req_len    = req_tdata[25:13];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_tready = 1'b1;

   assign eff_bytes  = (biu_ff > BIU_W'(MAP_BYTES)) ? BIU_W'(MAP_BYTES) : biu_ff;
   assign total_bits = {eff_bytes, 3'b000};
   assign idx_bad    = ({1'b0, req_idx} >= total_bits);
   assign len_bad    = (req_len == '0) || (req_len > total_bits);
   assign bit_mask   = BYTE_W'(1) << pos_ff;
   assign scan_start = {eval_ff[ADDR_W-1:0], step.pos} + LEN_W'(1) - len_ff;

   bra_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAP_BYTES)
   ) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bra_run_step u_step (
      .byte_data   (ram_rdata),
      .carry_count (run_cnt_ff),
      .run_length  (len_ff),
      .res         (step)
   );

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_state_in  = res_state_ff;
      res_start_in  = res_start_ff;
      res_status_in = res_status_ff;
      addr_in       = addr_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      len_in        = len_ff;
      run_cnt_in    = run_cnt_ff;
      eval_in       = eval_ff;
      next_addr_in  = next_addr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_state_in  = rsp_state_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = clr_addr_ff;
      ram_wdata     = '0;
      ram_raddr     = next_addr_ff[ADDR_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            ram_raddr = (req_op == OP_SCAN) ? '0 : ADDR_W'(req_idx >> POS_W);
            if (req_fire) begin
               res_state_in  = 1'b0;
               res_start_in  = '0;
               res_status_in = STATUS_OK;
               addr_in       = ADDR_W'(req_idx >> POS_W);
               pos_in        = req_idx[POS_W-1:0];
               val_in        = req_val;
               case (req_op)
                  OP_CLEAR: begin
                     clr_addr_in = '0;
                     clr_rsp_in  = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  OP_TEST, OP_WRITE: begin
                     if (idx_bad) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = (req_op == OP_TEST) ? ST_TEST : ST_WRUPD;
                     end
                  end
                  OP_SCAN: begin
                     if (len_bad) begin
                        res_status_in = STATUS_RANGE;
                        state_in      = ST_DONE;
                     end else begin
                        len_in       = req_len;
                        run_cnt_in   = '0;
                        eval_in      = '0;
                        next_addr_in = BIU_W'(1);
                        state_in     = ST_SCAN;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            ram_we      = 1'b1;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAP_BYTES - 1)) begin
               clr_rsp_in    = 1'b0;
               res_state_in  = 1'b0;
               res_start_in  = '0;
               res_status_in = STATUS_OK;
               state_in      = clr_rsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_TEST: begin
            res_state_in = ram_rdata[pos_ff];
            state_in     = ST_DONE;
         end
         ST_WRUPD: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = val_ff ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
            state_in  = ST_DONE;
         end
         ST_SCAN: begin
            if (step.found) begin
               res_start_in = scan_start[IDX_W-1:0];
               state_in     = ST_DONE;
            end else if (eval_ff == eff_bytes - BIU_W'(1)) begin
               res_status_in = STATUS_NO_RUN;
               state_in      = ST_DONE;
            end else begin
               eval_in      = eval_ff + BIU_W'(1);
               next_addr_in = next_addr_ff + BIU_W'(1);
               run_cnt_in   = step.next_count;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_state_in  = res_state_ff;
               rsp_start_in  = res_start_ff;
               rsp_status_in = res_status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      biu_in = biu_ff;
      if (csr_tvalid && csr_tready) begin
         biu_in = csr_tdata[BIU_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         clr_rsp_ff   <= 1'b0;
         biu_ff       <= BIU_W'(MAP_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_rsp_ff   <= clr_rsp_in;
         biu_ff       <= biu_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_state_ff  <= rsp_state_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_status_ff <= rsp_status_in;
      res_state_ff  <= res_state_in;
      res_start_ff  <= res_start_in;
      res_status_ff <= res_status_in;
      addr_ff       <= addr_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      len_ff        <= len_in;
      run_cnt_ff    <= run_cnt_in;
      eval_ff       <= eval_in;
      next_addr_ff  <= next_addr_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_start_ff, rsp_state_ff};
   assign rsp_tuser  = rsp_status_ff;

   `BRA_ASSERT_NEXT(a_accept_leaves_idle, req_fire, state_ff != ST_IDLE,
      "accepted word did not start the sequencer")
   `BRA_ASSERT(a_ram_write_owner,
      ram_we |-> (state_ff == ST_CLEAR || state_ff == ST_WRUPD),
      "bitmap written outside clear or bit update")
   `BRA_ASSERT(a_scan_in_bounds, (state_ff == ST_SCAN) |-> (eval_ff < eff_bytes),
      "scan evaluated a byte beyond the bytes in use")
   `BRA_ASSERT(a_run_fits,
      (state_ff == ST_SCAN && step.found) |->
         (({1'b0, scan_start} + {1'b0, len_ff}) <= {1'b0, total_bits}),
      "found run extends past the last valid bit")

endmodule

// ===== tb/sv/bitmap_run_allocator_check.sv =====
// Checker for bitmap_run_allocator: watches the request, result and register
// channels, keeps its own occupancy map and compares every result word.
// Depends on bra_pkg for sizes and the operation and status codes.
module bitmap_run_allocator_check
   import bra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_tvalid,
   input  logic        csr_tready,
   input  logic [15:0] csr_tdata,
   input  logic        wrap_up,
   output int          error_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic             bit_state;
      logic [IDX_W-1:0] run_start;
      status_type       status;
   } alloc_result_type;

   logic [BYTE_W-1:0] occupancy [MAP_BYTES];
   logic [BIU_W-1:0]  bytes_managed;
   alloc_result_type  answer_queue [$];
   int                mismatches = 0;

   assign error_count = mismatches;

   task automatic report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic int unsigned usable_bits();
      int unsigned live;
      live = (bytes_managed > MAP_BYTES) ? MAP_BYTES : bytes_managed;
      return live * BYTE_W;
   endfunction

   function automatic alloc_result_type apply_operation(op_type op, logic [IDX_W-1:0] idx,
                                                        logic val, logic [LEN_W-1:0] len);
      alloc_result_type res;
      int unsigned      total;
      int unsigned      run;
      int unsigned      pos;
      logic             hit;
      res   = '{bit_state: 1'b0, run_start: '0, status: STATUS_OK};
      total = usable_bits();
      run   = 0;
      hit   = 1'b0;
      case (op)
         OP_CLEAR: begin
            foreach (occupancy[b]) occupancy[b] = '0;
         end
         OP_TEST: begin
            if (idx >= total) res.status = STATUS_RANGE;
            else res.bit_state = occupancy[idx[IDX_W-1:POS_W]][idx[POS_W-1:0]];
         end
         OP_WRITE: begin
            if (idx >= total) res.status = STATUS_RANGE;
            else occupancy[idx[IDX_W-1:POS_W]][idx[POS_W-1:0]] = val;
         end
         default: begin
            if (len == 0 || len > total) begin
               res.status = STATUS_RANGE;
            end else begin
               for (pos = 0; pos < total && !hit; pos++) begin
                  if (occupancy[pos / BYTE_W][pos % BYTE_W]) run = 0;
                  else run++;
                  if (run == len) begin
                     hit = 1'b1;
                     res.run_start = IDX_W'(pos + 1 - len);
                  end
               end
               if (!hit) res.status = STATUS_NO_RUN;
            end
         end
      endcase
      return res;
   endfunction

   always @(posedge clock) begin
      alloc_result_type want;
      if (reset) begin
         foreach (occupancy[b]) occupancy[b] = '0;
         bytes_managed = BIU_W'(MAP_BYTES);
         answer_queue.delete();
      end else begin
         if (csr_tvalid && csr_tready) bytes_managed = csr_tdata[BIU_W-1:0];
         if (rsp_tvalid && rsp_tready) begin
            if (answer_queue.size() == 0) begin
               report("result word with no operation outstanding");
            end else begin
               want = answer_queue.pop_front();
               if (rsp_tdata[0] !== want.bit_state)
                  report($sformatf("bit_state got %0d, expected %0d",
                                   rsp_tdata[0], want.bit_state));
               if (rsp_tdata[IDX_W:1] !== want.run_start)
                  report($sformatf("run_start got %0d, expected %0d",
                                   rsp_tdata[IDX_W:1], want.run_start));
               if (rsp_tuser !== want.status)
                  report($sformatf("status got %0d, expected %0d",
                                   rsp_tuser, want.status));
            end
         end
         if (req_tvalid && req_tready)
            answer_queue.push_back(apply_operation(op_type'(req_tuser),
                                                   req_tdata[IDX_W-1:0],
                                                   req_tdata[IDX_W],
                                                   req_tdata[IDX_W+LEN_W:IDX_W+1]));
         if (wrap_up) begin
            foreach (answer_queue[n])
               report($sformatf("expected result %0d never arrived", n));
            answer_queue.delete();
         end
      end
   end

endmodule

// ===== tb/sv/bitmap_run_allocator_test.sv =====
// Top of the bitmap_run_allocator testbench: clock, reset, stimulus with bursty
// requests and a stalling receiver, and the verdict. Depends on bra_pkg, the
// block and bitmap_run_allocator_check.
module bitmap_run_allocator_test
   import bra_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 4_000_000;
   localparam int HOLD_CYCLES = 300;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = OP_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [15:0] csr_tdata  = '0;
   logic        wrap_up    = 1'b0;
   int          error_count;

   int unsigned sent_words = 0;
   int unsigned done_words = 0;
   int unsigned map_bits   = MAP_BYTES * BYTE_W;
   int unsigned burst_left = 0;
   int unsigned map_sizes  = 1;
   int unsigned cycle_count = 0;
   int unsigned hold_token = 0;
   int unsigned hold_seen  = 0;
   int unsigned hold_left  = 0;
   int unsigned stall_left = 0;
   int unsigned stall_mode = 0;

   bitmap_run_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   bitmap_run_allocator_check allocator_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_tvalid  (csr_tvalid),
      .csr_tready  (csr_tready),
      .csr_tdata   (csr_tdata),
      .wrap_up     (wrap_up),
      .error_count (error_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d results in", cycle_count,
                  done_words, sent_words);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) done_words <= done_words + 1;

   always @(posedge clock) begin
      if (hold_token != hold_seen) begin
         hold_seen = hold_token;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(16, 160);
         end
         stall_left--;
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= 1'($urandom_range(0, 1));
            default: rsp_tready <= (stall_left % 4 != 0);
         endcase
      end
   end

   task automatic push_word(op_type op, int unsigned idx, logic val, int unsigned len);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'd0, LEN_W'(len), val, IDX_W'(idx)};
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (done_words != sent_words) @(posedge clock);
   endtask

   task automatic set_map_bytes(int unsigned bytes);
      drain();
      csr_tvalid <= 1'b1;
      csr_tdata  <= 16'(bytes);
      do @(posedge clock); while (!csr_tready);
      csr_tvalid <= 1'b0;
      map_bits = ((bytes > MAP_BYTES) ? MAP_BYTES : bytes) * BYTE_W;
      map_sizes++;
   endtask

   function automatic int unsigned pick_index();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (map_bits == 0 || r < 5) return $urandom_range(0, 4095);
      if (r < 15) return (map_bits + $urandom_range(0, 7) > 4095) ? 4095
                                                                   : map_bits + $urandom_range(0, 7);
      return $urandom_range(0, map_bits - 1);
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 4) return 0;
      if (r < 9) return $urandom_range(0, 8191);
      if (r < 17) return map_bits + $urandom_range(0, 3);
      if (map_bits == 0) return 1;
      if (r < 30) return $urandom_range(1, map_bits);
      return $urandom_range(1, (map_bits < 24) ? map_bits : 24);
   endfunction

   task automatic random_words(int count);
      int          left;
      int unsigned r;
      int unsigned first;
      int unsigned span;
      logic        val;
      left = count;
      while (left > 0) begin
         r = $urandom_range(0, 99);
         if (r < 2) begin
            push_word(OP_CLEAR, $urandom_range(0, 4095), 1'($urandom), $urandom_range(0, 8191));
            left--;
         end else if (r < 14) begin
            // mark or free a run of neighboring bits, as an allocation would
            first = pick_index();
            span  = $urandom_range(2, 16);
            val   = ($urandom_range(0, 9) < 7);
            for (int k = 0; k < span && first + k <= 4095; k++)
               push_word(OP_WRITE, first + k, val, $urandom_range(0, 8191));
            left -= span;
         end else if (r < 32) begin
            push_word(OP_WRITE, pick_index(), ($urandom_range(0, 9) < 6),
                      $urandom_range(0, 8191));
            left--;
         end else if (r < 50) begin
            push_word(OP_TEST, pick_index(), 1'($urandom), $urandom_range(0, 8191));
            left--;
         end else begin
            push_word(OP_SCAN, $urandom_range(0, 4095), 1'($urandom), pick_length());
            left--;
         end
         if ($urandom_range(0, 99) == 0) drain();
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // full 512-byte map: edges, byte boundaries, no-run and clear
      push_word(OP_TEST,  0,    1'b0, 0);
      push_word(OP_SCAN,  0,    1'b0, 4096);
      push_word(OP_SCAN,  0,    1'b0, 4097);
      push_word(OP_SCAN,  0,    1'b0, 0);
      push_word(OP_SCAN,  4095, 1'b1, 8191);
      push_word(OP_WRITE, 0,    1'b1, 0);
      push_word(OP_WRITE, 4095, 1'b1, 8191);
      push_word(OP_TEST,  4095, 1'b0, 0);
      push_word(OP_TEST,  0,    1'b1, 0);
      push_word(OP_SCAN,  0,    1'b0, 4095);
      push_word(OP_SCAN,  0,    1'b0, 4094);
      push_word(OP_WRITE, 7,    1'b1, 0);
      push_word(OP_WRITE, 8,    1'b1, 0);
      push_word(OP_SCAN,  0,    1'b0, 1);
      push_word(OP_WRITE, 0,    1'b0, 0);
      push_word(OP_SCAN,  0,    1'b0, 1);
      push_word(OP_WRITE, 4095, 1'b0, 0);
      push_word(OP_TEST,  4095, 1'b1, 0);
      push_word(OP_WRITE, 2048, 1'b1, 0);
      push_word(OP_SCAN,  0,    1'b0, 2048);
      push_word(OP_SCAN,  0,    1'b0, 2047);
      push_word(OP_SCAN,  0,    1'b0, 7);
      push_word(OP_CLEAR, 4095, 1'b1, 8191);
      push_word(OP_TEST,  7,    1'b0, 0);
      push_word(OP_SCAN,  0,    1'b0, 4096);

      set_map_bytes(1);
      random_words(40);
      set_map_bytes(0);
      random_words(25);
      set_map_bytes(2);
      random_words(60);
      set_map_bytes(1023);
      random_words(60);
      set_map_bytes(16);
      hold_token <= hold_token + 1;
      random_words(150);
      set_map_bytes(5);
      random_words(120);
      set_map_bytes(64);
      hold_token <= hold_token + 1;
      random_words(200);
      set_map_bytes(513);
      random_words(60);
      set_map_bytes(512);
      random_words(100);
      set_map_bytes(32);
      random_words(150);
      set_map_bytes($urandom_range(3, 40));
      random_words(180);

      drain();
      repeat (600) @(posedge clock);
      wrap_up <= 1'b1;
      repeat (2) @(posedge clock);
      $display("Covered %0d operations (clear, test, write, scan) over %0d map size settings,",
               sent_words, map_sizes);
      $display("including empty, one-byte, oversize and full maps; %0d results compared.",
               done_words);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches", error_count);
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
